>>> design/nearest_site_periodic_match_defines.svh
// ---------------------------------------------------------------------------
// nearest_site_periodic_match_defines.svh
// assertion macros shared by the nearest site matcher
// ---------------------------------------------------------------------------
`ifndef NEAREST_SITE_PERIODIC_MATCH_DEFINES_SVH
`define NEAREST_SITE_PERIODIC_MATCH_DEFINES_SVH

// consequence checked in the same cycle as the condition
`define NSP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("nsp: same-cycle check failed");

// consequence checked in the cycle after the condition
`define NSP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("nsp: next-cycle check failed");

`endif

>>> design/nsp_pkg.sv
// ---------------------------------------------------------------------------
// nsp_pkg
// types and constants of the nearest site matcher
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package nsp_pkg;

   localparam int COORD_W   = 20;
   localparam int NUM_AXES  = 3;
   localparam int SITE_W    = COORD_W * NUM_AXES;
   localparam int DIST_W    = 2 * COORD_W;
   localparam int ACC_W     = DIST_W + 2;
   localparam int NIDX_W    = 10;
   localparam int NPTS_W    = 11;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 40;

   // item kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_X      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_Y      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_Z      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_POINTS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_THR    = 3'd4;

   // register reset values
   localparam logic [COORD_W-1:0] BOX_RESET     = 20'hFFFFF;
   localparam logic [NPTS_W-1:0]  NPTS_RESET    = 11'd0;
   localparam logic [DIST_W-1:0]  OFF_THR_RESET = 40'd513802;

   // one site moving down the cell row
   typedef struct packed {
      logic              valid;
      logic              last;
      logic [SITE_W-1:0] site;
      logic [ACC_W-1:0]  acc;
   } beat_type;

   // one result item
   typedef struct packed {
      logic [NIDX_W-1:0] nearest_index;
      logic [DIST_W-1:0] dist_sq;
      logic              off_lattice;
      logic              found;
   } result_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT,
      ST_PUT
   } state_type;

endpackage

>>> design/nearest_site_periodic_match.sv
// ---------------------------------------------------------------------------
// nearest_site_periodic_match
// nearest lattice site of a position under periodic minimum image distance
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  kind, site_index, pos_x/y/z
//   rsp      out        rsp_valid / rsp_ready  nearest_index, dist_sq,
//                                              off_lattice, found
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// a load writes one site to the ram. a query item reads count sites, where
// count is num_points clipped to MAX_POINTS: the site ram is read once per
// cycle and each site passes a row of three axis cells, three stages each.
// an empty query skips the scan and gives all zeros. one item is in work at a
// time; a finished result waits in the output register while the next item
// is taken. reset is synchronous and needs no clearing pass; the site ram is
// not cleared. csr writes are taken every cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nearest_site_periodic_match_defines.svh"

module nearest_site_periodic_match #(
   parameter int MAX_POINTS = 1024
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_kind,
   input  logic [9:0]                     req_site_index,
   input  logic [nsp_pkg::COORD_W-1:0]    req_pos_x,
   input  logic [nsp_pkg::COORD_W-1:0]    req_pos_y,
   input  logic [nsp_pkg::COORD_W-1:0]    req_pos_z,

   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [nsp_pkg::NIDX_W-1:0]     rsp_nearest_index,
   output logic [nsp_pkg::DIST_W-1:0]     rsp_dist_sq,
   output logic                           rsp_off_lattice,
   output logic                           rsp_found,

   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [nsp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [nsp_pkg::CSR_DAT_W-1:0]  csr_data
);

   import nsp_pkg::*;

   localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);

   // configuration registers
   logic [COORD_W-1:0]      box_ff [0:NUM_AXES-1];
   logic [NPTS_W-1:0]       num_points_ff;
   logic [DIST_W-1:0]       off_thr_ff;

   // control
   state_type               state_ff, state_in;
   logic                    req_take, scan_on, put_on;
   logic                    req_acc, is_load, is_query;
   logic [ADDR_W-1:0]       rd_addr_ff;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W+NPTS_W-1:0] npts_wide;
   logic                    count_zero;
   logic                    scan_last;
   logic                    empty_ff;
   logic                    iss_valid_ff, iss_last_ff;
   logic [COORD_W-1:0]      qpos_ff [0:NUM_AXES-1];

   // site ram
   logic [ADDR_W+9:0]       wr_wide;
   logic                    wr_in_range, wr_en;
   logic [SITE_W-1:0]       rd_data;

   // cell row and result
   beat_type                chain [0:NUM_AXES];
   logic                    trk_done;
   result_type              trk_result;
   logic                    slot_free;
   logic                    rsp_valid_ff;
   result_type              rsp_data_ff;

   assign csr_ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff[0]     <= BOX_RESET;
         box_ff[1]     <= BOX_RESET;
         box_ff[2]     <= BOX_RESET;
         num_points_ff <= NPTS_RESET;
         off_thr_ff    <= OFF_THR_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BOX_X:      box_ff[0]     <= csr_data[COORD_W-1:0];
            CSR_BOX_Y:      box_ff[1]     <= csr_data[COORD_W-1:0];
            CSR_BOX_Z:      box_ff[2]     <= csr_data[COORD_W-1:0];
            CSR_NUM_POINTS: num_points_ff <= csr_data[NPTS_W-1:0];
            CSR_OFF_THR:    off_thr_ff    <= csr_data[DIST_W-1:0];
            default: ;
         endcase
      end
   end

   // item decode
   assign req_acc  = req_valid && req_ready;
   assign is_load  = req_acc && (req_kind == KIND_LOAD);
   assign is_query = req_acc && (req_kind == KIND_QUERY);

   // sites scanned per query, clipped to the table size
   always_comb begin
      npts_wide = {{CNT_W{1'b0}}, num_points_ff};
      if (npts_wide > (CNT_W + NPTS_W)'(MAX_POINTS)) begin
         count_in = CNT_W'(MAX_POINTS);
      end else begin
         count_in = npts_wide[CNT_W-1:0];
      end
      count_zero = (count_in == '0);
   end

   assign scan_last = ((CNT_W'(rd_addr_ff) + CNT_W'(1)) == count_ff);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (is_query) begin
               state_in = count_zero ? ST_PUT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (trk_done) begin
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_take = 1'b0;
      scan_on  = 1'b0;
      put_on   = 1'b0;
      case (state_ff)
         ST_IDLE: req_take = 1'b1;
         ST_SCAN: scan_on  = 1'b1;
         ST_PUT:  put_on   = 1'b1;
         ST_WAIT: ;
         default: ;
      endcase
   end

   assign req_ready = req_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // query setup and read address counter
   always_ff @(posedge clock) begin
      if (is_query) begin
         qpos_ff[0] <= req_pos_x;
         qpos_ff[1] <= req_pos_y;
         qpos_ff[2] <= req_pos_z;
         count_ff   <= count_in;
         empty_ff   <= count_zero;
         rd_addr_ff <= '0;
      end else if (scan_on) begin
         rd_addr_ff <= rd_addr_ff + 1'b1;
      end
   end

   // read issue flags, aligned with the ram read data
   always_ff @(posedge clock) begin
      if (reset) begin
         iss_valid_ff <= 1'b0;
         iss_last_ff  <= 1'b0;
      end else begin
         iss_valid_ff <= scan_on;
         iss_last_ff  <= scan_on && scan_last;
      end
   end

   // site loads, slots beyond the table are dropped
   always_comb begin
      wr_wide     = {{ADDR_W{1'b0}}, req_site_index};
      wr_in_range = wr_wide < (ADDR_W + 10)'(MAX_POINTS);
      wr_en       = is_load && wr_in_range;
   end

   nsp_ram #(
      .WIDTH (SITE_W),
      .DEPTH (MAX_POINTS)
   ) u_site_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_wide[ADDR_W-1:0]),
      .wr_data ({req_pos_z, req_pos_y, req_pos_x}),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   // row of axis cells, x first
   always_comb begin
      chain[0].valid = iss_valid_ff;
      chain[0].last  = iss_last_ff;
      chain[0].site  = rd_data;
      chain[0].acc   = '0;
   end

   for (genvar g = 0; g < NUM_AXES; g++) begin : g_cell
      nsp_axis_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .beat_in   (chain[g]),
         .pos_coord (qpos_ff[g]),
         .box_len   (box_ff[g]),
         .beat_out  (chain[g+1])
      );
   end

   nsp_min_track #(
      .IDX_W (ADDR_W)
   ) u_min_track (
      .clock            (clock),
      .reset            (reset),
      .beat_in          (chain[NUM_AXES]),
      .off_threshold_sq (off_thr_ff),
      .done             (trk_done),
      .result           (trk_result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (put_on && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (put_on && slot_free) begin
         rsp_data_ff <= empty_ff ? '0 : trk_result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_nearest_index = rsp_data_ff.nearest_index;
   assign rsp_dist_sq       = rsp_data_ff.dist_sq;
   assign rsp_off_lattice   = rsp_data_ff.off_lattice;
   assign rsp_found         = rsp_data_ff.found;

   // checks
   `NSP_ASSERT_NOW(a_done_in_wait, trk_done, state_ff == ST_WAIT)
   `NSP_ASSERT_NOW(a_row_empty_idle, state_ff == ST_IDLE, !chain[NUM_AXES].valid)
   `NSP_ASSERT_NEXT(a_put_shows, put_on && slot_free, rsp_valid_ff)
   `NSP_ASSERT_NOW(a_empty_zero, rsp_valid_ff && !rsp_found,
                   (rsp_dist_sq == '0) && (rsp_nearest_index == '0) && !rsp_off_lattice)

endmodule

>>> design/nsp_ram.sv
// ---------------------------------------------------------------------------
// nsp_ram
// simple dual port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nsp_ram #(
   parameter int WIDTH = 60,
   parameter int DEPTH = 1024
) (
   input  logic                                            clock,
   input  logic                                            wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    wr_addr,
   input  logic [WIDTH-1:0]                                wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    rd_addr,
   output logic [WIDTH-1:0]                                rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/nsp_axis_cell.sv
// ---------------------------------------------------------------------------
// nsp_axis_cell
// one cell of the distance row: wraps one axis difference, squares it and
// adds it to the running sum, then hands the site on with the next axis
// shifted into the low coordinate slot
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nsp_axis_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  nsp_pkg::beat_type            beat_in,
   input  logic [nsp_pkg::COORD_W-1:0]  pos_coord,
   input  logic [nsp_pkg::COORD_W-1:0]  box_len,
   output nsp_pkg::beat_type            beat_out
);

   import nsp_pkg::*;

   logic [COORD_W-1:0]         site_coord;
   logic signed [COORD_W+1:0]  diff;
   logic signed [COORD_W+1:0]  diff_hi;
   logic signed [COORD_W+1:0]  diff_lo;
   logic signed [COORD_W+2:0]  twice;
   logic signed [COORD_W+2:0]  box_pos;
   logic signed [COORD_W+2:0]  box_neg;
   logic signed [COORD_W+1:0]  wrap_in;
   logic signed [COORD_W+1:0]  wrap_ff;
   logic signed [COORD_W+1:0]  mag;
   logic [DIST_W-1:0]          sq_in;
   logic [DIST_W-1:0]          sq_ff;

   logic                       a_valid_ff, a_last_ff;
   logic [SITE_W-1:0]          a_site_ff;
   logic [ACC_W-1:0]           a_acc_ff;
   logic                       b_valid_ff, b_last_ff;
   logic [SITE_W-1:0]          b_site_ff;
   logic [ACC_W-1:0]           b_acc_ff;
   logic                       out_valid_ff, out_last_ff;
   logic [SITE_W-1:0]          out_site_ff;
   logic [ACC_W-1:0]           out_acc_ff;

   assign site_coord = beat_in.site[COORD_W-1:0];

   // minimum image wrap, a single correction by one box
   always_comb begin
      diff    = $signed({2'b00, pos_coord}) - $signed({2'b00, site_coord});
      diff_hi = diff - $signed({2'b00, box_len});
      diff_lo = diff + $signed({2'b00, box_len});
      twice   = $signed({diff, 1'b0});
      box_pos = $signed({3'b000, box_len});
      box_neg = -box_pos;
      if (twice > box_pos) begin
         wrap_in = diff_hi;
      end else if (twice < box_neg) begin
         wrap_in = diff_lo;
      end else begin
         wrap_in = diff;
      end
   end

   // magnitude and square
   always_comb begin
      mag   = wrap_ff[COORD_W+1] ? -wrap_ff : wrap_ff;
      sq_in = mag[COORD_W-1:0] * mag[COORD_W-1:0];
   end

   // stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         a_last_ff    <= 1'b0;
         b_valid_ff   <= 1'b0;
         b_last_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
         out_last_ff  <= 1'b0;
      end else begin
         a_valid_ff   <= beat_in.valid;
         a_last_ff    <= beat_in.last;
         b_valid_ff   <= a_valid_ff;
         b_last_ff    <= a_last_ff;
         out_valid_ff <= b_valid_ff;
         out_last_ff  <= b_last_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      a_site_ff   <= beat_in.site;
      a_acc_ff    <= beat_in.acc;
      wrap_ff     <= wrap_in;
      b_site_ff   <= a_site_ff;
      b_acc_ff    <= a_acc_ff;
      sq_ff       <= sq_in;
      out_site_ff <= {{COORD_W{1'b0}}, b_site_ff[SITE_W-1:COORD_W]};
      out_acc_ff  <= b_acc_ff + {2'b00, sq_ff};
   end

   always_comb begin
      beat_out.valid = out_valid_ff;
      beat_out.last  = out_last_ff;
      beat_out.site  = out_site_ff;
      beat_out.acc   = out_acc_ff;
   end

endmodule

>>> design/nsp_min_track.sv
// ---------------------------------------------------------------------------
// nsp_min_track
// end of the cell row: keeps the smallest distance and its site index
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nsp_min_track #(
   parameter int IDX_W = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  nsp_pkg::beat_type           beat_in,
   input  logic [nsp_pkg::DIST_W-1:0]  off_threshold_sq,
   output logic                        done,
   output nsp_pkg::result_type         result
);

   import nsp_pkg::*;

   logic [IDX_W-1:0]         idx_ff;
   logic                     seen_ff;
   logic                     done_ff;
   logic [ACC_W-1:0]         best_d_ff;
   logic [IDX_W-1:0]         best_idx_ff;
   logic                     take;
   logic [IDX_W+NIDX_W-1:0]  idx_wide;

   // first site, or strictly closer: lowest index wins ties
   assign take = beat_in.valid && (!seen_ff || (beat_in.acc < best_d_ff));

   // index counter and query bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         seen_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= beat_in.valid && beat_in.last;
         if (beat_in.valid) begin
            idx_ff  <= beat_in.last ? '0 : idx_ff + 1'b1;
            seen_ff <= !beat_in.last;
         end
      end
   end

   // running best
   always_ff @(posedge clock) begin
      if (take) begin
         best_d_ff   <= beat_in.acc;
         best_idx_ff <= idx_ff;
      end
   end

   // result fields
   always_comb begin
      idx_wide             = {{NIDX_W{1'b0}}, best_idx_ff};
      result.nearest_index = idx_wide[NIDX_W-1:0];
      result.dist_sq       = (best_d_ff[ACC_W-1:DIST_W] != 2'b00) ? {DIST_W{1'b1}}
                                                                  : best_d_ff[DIST_W-1:0];
      result.off_lattice   = best_d_ff > {2'b00, off_threshold_sq};
      result.found         = 1'b1;
   end

   assign done = done_ff;

endmodule
